### hdl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg: three-level task scheduler shared types and codes
// Operation, class, slot state and status codes used by the scheduler.
// ----------------------------------------------------------------------------
package tls_pkg;

   typedef enum logic [2:0] {
      OP_CREATE    = 3'd0,
      OP_START     = 3'd1,
      OP_YIELD     = 3'd2,
      OP_TERMINATE = 3'd3,
      OP_MS_TICK   = 3'd4,
      OP_PER_TICK  = 3'd5
   } op_type;

   localparam logic [1:0] CL_SYSTEM   = 2'd0;
   localparam logic [1:0] CL_PERIODIC = 2'd1;
   localparam logic [1:0] CL_RR       = 2'd2;

   localparam logic [1:0] ST_DEAD    = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_WAITING = 2'd3;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_IGNORED = 2'd2;
   localparam logic [1:0] STS_HALTED  = 2'd3;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_SEARCH = 8'b0000_0100,
      S_WALK   = 8'b0000_1000,
      S_WALK2  = 8'b0001_0000,
      S_SHIFT  = 8'b0010_0000,
      S_DISP   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

endpackage

### hdl/three_level_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// three_level_task_scheduler_unit: three-class hardware task scheduler
// states: an accepted item passes S_DECODE, then S_SEARCH for a create, S_WALK
//   for a period tick or S_SHIFT and S_WALK2 for a periodic terminate (walking
//   the slot table or list), S_DISP when a dispatch follows, then S_DONE
// one item at a time: busy is high from acceptance until the strobe cycle
// the slot walk runs through a single shared decrement and compare unit
// synchronous reset clears the state machine, slot tables and queue pointers; quantum resets to 10
// ----------------------------------------------------------------------------
module three_level_task_scheduler_unit #(
   parameter int MAX_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_task_class,
   input  logic [15:0] req_period,
   input  logic [15:0] req_offset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output logic        rsp_valid,
   output logic [3:0]  rsp_running_task,
   output logic        rsp_running_valid,
   output logic [3:0]  rsp_created_task,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_time_ms
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_TASKS);
   localparam logic [IW-1:0] LASTI = IW'(MAX_TASKS - 1);

   // slot tables
   logic [1:0]  slot_state_ff [MAX_TASKS];
   logic [1:0]  slot_class_ff [MAX_TASKS];
   logic [15:0] slot_period_ff [MAX_TASKS];
   logic [15:0] slot_cd_ff [MAX_TASKS];
   logic [IW-1:0] sys_fifo_ff [MAX_TASKS];
   logic [IW-1:0] rot_fifo_ff [MAX_TASKS];
   logic [IW-1:0] plist_ff [MAX_TASKS];

   logic [IW-1:0] sys_head_ff, sys_tail_ff, rot_head_ff, rot_tail_ff;
   logic [CW-1:0] sys_cnt_ff, rot_cnt_ff, pcnt_ff, live_ff;
   logic          pr_valid_ff, run_valid_ff, started_ff, halted_ff;
   logic [IW-1:0] pr_id_ff, cur_ff;
   logic [15:0]   ms_ff;
   logic [7:0]    quantum_ff;

   tls_pkg::state_type state_ff;
   logic [2:0]    op_ff;
   logic [1:0]    cls_ff;
   logic [15:0]   per_ff, off_ff;
   logic [CW-1:0] idx_ff;
   logic [1:0]    sts_ff;
   logic [IW-1:0] made_ff;

   logic [15:0] eq;
   assign eq = (quantum_ff == 8'd0) ? 16'd1 : {8'd0, quantum_ff};

   // shared decrement unit on the slot countdown
   logic [IW-1:0] walk_id;
   logic [IW-1:0] dec_id;
   logic [15:0]   dec_q;
   assign walk_id = plist_ff[idx_ff[IW-1:0]];
   assign dec_id  = (state_ff == tls_pkg::S_WALK) ? walk_id : cur_ff;
   assign dec_q   = slot_cd_ff[dec_id] - 16'd1;

   logic [IW-1:0] cur_cls_id;
   logic [1:0]    cur_cls;
   assign cur_cls_id = cur_ff;
   assign cur_cls = slot_class_ff[cur_cls_id];

   assign busy = (state_ff != tls_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         state_ff <= tls_pkg::S_IDLE;
         for (int i = 0; i < MAX_TASKS; i++) begin
            slot_state_ff[i] <= tls_pkg::ST_DEAD;
            slot_class_ff[i] <= 2'd0;
            slot_period_ff[i] <= 16'd0;
            slot_cd_ff[i] <= 16'd0;
         end
         sys_head_ff <= '0; sys_tail_ff <= '0; sys_cnt_ff <= '0;
         rot_head_ff <= '0; rot_tail_ff <= '0; rot_cnt_ff <= '0;
         pcnt_ff <= '0; live_ff <= '0;
         pr_valid_ff <= 1'b0; pr_id_ff <= '0; cur_ff <= '0;
         run_valid_ff <= 1'b0; started_ff <= 1'b0; halted_ff <= 1'b0;
         ms_ff <= 16'd0; quantum_ff <= 8'd10;
      end else begin
         rsp_valid <= (state_ff == tls_pkg::S_DONE);
         if (csr_we) quantum_ff <= csr_wdata;
         case (state_ff)
            // accept an item
            tls_pkg::S_IDLE: begin
               if (start) begin
                  op_ff <= req_op; cls_ff <= req_task_class;
                  per_ff <= req_period; off_ff <= req_offset;
                  sts_ff <= tls_pkg::STS_OK; made_ff <= '0; idx_ff <= '0;
                  state_ff <= tls_pkg::S_DECODE;
               end
            end
            // decode the event
            tls_pkg::S_DECODE: begin
               state_ff <= tls_pkg::S_DONE;
               if (halted_ff) sts_ff <= tls_pkg::STS_IGNORED;
               else case (op_ff)
                  tls_pkg::OP_CREATE: begin
                     if (cls_ff == 2'd3) sts_ff <= tls_pkg::STS_IGNORED;
                     else if (live_ff >= MAXC) sts_ff <= tls_pkg::STS_FULL;
                     else state_ff <= tls_pkg::S_SEARCH;
                  end
                  tls_pkg::OP_START: begin
                     if (started_ff || live_ff == '0) sts_ff <= tls_pkg::STS_IGNORED;
                     else begin
                        started_ff <= 1'b1; state_ff <= tls_pkg::S_DISP;
                     end
                  end
                  tls_pkg::OP_YIELD: begin
                     if (!started_ff) sts_ff <= tls_pkg::STS_IGNORED;
                     else begin
                        state_ff <= tls_pkg::S_DISP;
                        if (run_valid_ff) begin
                           run_valid_ff <= 1'b0;
                           if (cur_cls == tls_pkg::CL_PERIODIC)
                              slot_state_ff[cur_ff] <= tls_pkg::ST_WAITING;
                           else begin
                              slot_state_ff[cur_ff] <= tls_pkg::ST_READY;
                              if (cur_cls == tls_pkg::CL_SYSTEM) begin
                                 if (sys_cnt_ff < MAXC) begin
                                    sys_fifo_ff[sys_tail_ff] <= cur_ff;
                                    sys_tail_ff <= (sys_tail_ff == LASTI) ? '0
                                                   : sys_tail_ff + 1'b1;
                                    sys_cnt_ff <= sys_cnt_ff + 1'b1;
                                 end
                              end else if (rot_cnt_ff < MAXC) begin
                                 rot_fifo_ff[rot_tail_ff] <= cur_ff;
                                 rot_tail_ff <= (rot_tail_ff == LASTI) ? '0
                                                : rot_tail_ff + 1'b1;
                                 rot_cnt_ff <= rot_cnt_ff + 1'b1;
                              end
                           end
                        end
                     end
                  end
                  tls_pkg::OP_TERMINATE: begin
                     if (!started_ff) sts_ff <= tls_pkg::STS_IGNORED;
                     else begin
                        state_ff <= tls_pkg::S_DISP;
                        if (run_valid_ff) begin
                           run_valid_ff <= 1'b0;
                           slot_state_ff[cur_ff] <= tls_pkg::ST_DEAD;
                           if (live_ff != '0) live_ff <= live_ff - 1'b1;
                           if (cur_cls == tls_pkg::CL_PERIODIC) begin
                              if (pr_valid_ff && pr_id_ff == cur_ff)
                                 pr_valid_ff <= 1'b0;
                              state_ff <= tls_pkg::S_SHIFT;
                           end
                        end
                     end
                  end
                  tls_pkg::OP_MS_TICK: begin
                     ms_ff <= ms_ff + 16'd1;
                     if (started_ff) begin
                        if (!run_valid_ff) state_ff <= tls_pkg::S_DISP;
                        else begin : tick
                           logic pre;
                           pre = (cur_cls == tls_pkg::CL_RR &&
                                  (sys_cnt_ff != '0 || pr_valid_ff)) ||
                                 (cur_cls == tls_pkg::CL_PERIODIC && sys_cnt_ff != '0);
                           if (cur_cls == tls_pkg::CL_RR) begin
                              if (dec_q == 16'd0) begin
                                 slot_cd_ff[cur_ff] <= eq; pre = 1'b1;
                              end else slot_cd_ff[cur_ff] <= dec_q;
                           end
                           if (pre) begin
                              slot_state_ff[cur_ff] <= tls_pkg::ST_READY;
                              if (cur_cls == tls_pkg::CL_PERIODIC && pr_valid_ff) begin
                                 halted_ff <= 1'b1; sts_ff <= tls_pkg::STS_HALTED;
                              end else begin
                                 run_valid_ff <= 1'b0;
                                 state_ff <= tls_pkg::S_DISP;
                                 if (cur_cls == tls_pkg::CL_PERIODIC) begin
                                    pr_valid_ff <= 1'b1; pr_id_ff <= cur_ff;
                                 end else if (cur_cls == tls_pkg::CL_SYSTEM) begin
                                    if (sys_cnt_ff < MAXC) begin
                                       sys_fifo_ff[sys_tail_ff] <= cur_ff;
                                       sys_tail_ff <= (sys_tail_ff == LASTI) ? '0
                                                      : sys_tail_ff + 1'b1;
                                       sys_cnt_ff <= sys_cnt_ff + 1'b1;
                                    end
                                 end else if (rot_cnt_ff < MAXC) begin
                                    rot_fifo_ff[rot_tail_ff] <= cur_ff;
                                    rot_tail_ff <= (rot_tail_ff == LASTI) ? '0
                                                   : rot_tail_ff + 1'b1;
                                    rot_cnt_ff <= rot_cnt_ff + 1'b1;
                                 end
                              end
                           end
                        end
                     end
                  end
                  tls_pkg::OP_PER_TICK: state_ff <= tls_pkg::S_WALK;
                  default: sts_ff <= tls_pkg::STS_IGNORED;
               endcase
            end
            // find the first dead slot, one per cycle
            tls_pkg::S_SEARCH: begin
               if (idx_ff >= MAXC) begin
                  sts_ff <= tls_pkg::STS_FULL; state_ff <= tls_pkg::S_DONE;
               end else if (slot_state_ff[idx_ff[IW-1:0]] == tls_pkg::ST_DEAD) begin
                  slot_class_ff[idx_ff[IW-1:0]] <= cls_ff;
                  slot_period_ff[idx_ff[IW-1:0]] <= 16'd0;
                  slot_cd_ff[idx_ff[IW-1:0]] <= 16'd0;
                  made_ff <= idx_ff[IW-1:0];
                  live_ff <= live_ff + 1'b1;
                  state_ff <= tls_pkg::S_DONE;
                  if (cls_ff == tls_pkg::CL_SYSTEM) begin
                     slot_state_ff[idx_ff[IW-1:0]] <= tls_pkg::ST_READY;
                     if (sys_cnt_ff < MAXC) begin
                        sys_fifo_ff[sys_tail_ff] <= idx_ff[IW-1:0];
                        sys_tail_ff <= (sys_tail_ff == LASTI) ? '0 : sys_tail_ff + 1'b1;
                        sys_cnt_ff <= sys_cnt_ff + 1'b1;
                     end
                  end else if (cls_ff == tls_pkg::CL_PERIODIC) begin
                     slot_state_ff[idx_ff[IW-1:0]] <= tls_pkg::ST_WAITING;
                     slot_period_ff[idx_ff[IW-1:0]] <= per_ff;
                     slot_cd_ff[idx_ff[IW-1:0]] <= off_ff;
                     if (pcnt_ff < MAXC) begin
                        plist_ff[pcnt_ff[IW-1:0]] <= idx_ff[IW-1:0];
                        pcnt_ff <= pcnt_ff + 1'b1;
                     end
                  end else begin
                     slot_state_ff[idx_ff[IW-1:0]] <= tls_pkg::ST_READY;
                     slot_cd_ff[idx_ff[IW-1:0]] <= eq;
                     if (rot_cnt_ff < MAXC) begin
                        rot_fifo_ff[rot_tail_ff] <= idx_ff[IW-1:0];
                        rot_tail_ff <= (rot_tail_ff == LASTI) ? '0 : rot_tail_ff + 1'b1;
                        rot_cnt_ff <= rot_cnt_ff + 1'b1;
                     end
                  end
               end else idx_ff <= idx_ff + 1'b1;
            end
            // period tick walk over the periodic list
            tls_pkg::S_WALK: begin
               if (idx_ff >= pcnt_ff) state_ff <= tls_pkg::S_DONE;
               else if (dec_q == 16'd0) begin
                  slot_cd_ff[walk_id] <= slot_period_ff[walk_id];
                  if (slot_state_ff[walk_id] != tls_pkg::ST_RUNNING)
                     slot_state_ff[walk_id] <= tls_pkg::ST_READY;
                  if (pr_valid_ff) begin
                     halted_ff <= 1'b1; sts_ff <= tls_pkg::STS_HALTED;
                     state_ff <= tls_pkg::S_DONE;
                  end else begin
                     pr_valid_ff <= 1'b1; pr_id_ff <= walk_id;
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  slot_cd_ff[walk_id] <= dec_q;
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // locate the terminated task in the periodic list
            tls_pkg::S_SHIFT: begin
               if (idx_ff >= pcnt_ff) state_ff <= tls_pkg::S_DISP;
               else if (plist_ff[idx_ff[IW-1:0]] == cur_ff) state_ff <= tls_pkg::S_WALK2;
               else idx_ff <= idx_ff + 1'b1;
            end
            // close the gap, one entry per cycle
            tls_pkg::S_WALK2: begin
               if (idx_ff + 1'b1 < pcnt_ff) begin
                  plist_ff[idx_ff[IW-1:0]] <= plist_ff[idx_ff[IW-1:0] + 1'b1];
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  pcnt_ff <= pcnt_ff - 1'b1;
                  state_ff <= tls_pkg::S_DISP;
               end
            end
            // pick the next task to run
            tls_pkg::S_DISP: begin
               state_ff <= tls_pkg::S_DONE;
               if (sys_cnt_ff != '0) begin
                  cur_ff <= sys_fifo_ff[sys_head_ff]; run_valid_ff <= 1'b1;
                  slot_state_ff[sys_fifo_ff[sys_head_ff]] <= tls_pkg::ST_RUNNING;
                  sys_head_ff <= (sys_head_ff == LASTI) ? '0 : sys_head_ff + 1'b1;
                  sys_cnt_ff <= sys_cnt_ff - 1'b1;
               end else if (pr_valid_ff) begin
                  cur_ff <= pr_id_ff; run_valid_ff <= 1'b1; pr_valid_ff <= 1'b0;
                  slot_state_ff[pr_id_ff] <= tls_pkg::ST_RUNNING;
               end else if (rot_cnt_ff != '0) begin
                  cur_ff <= rot_fifo_ff[rot_head_ff]; run_valid_ff <= 1'b1;
                  slot_state_ff[rot_fifo_ff[rot_head_ff]] <= tls_pkg::ST_RUNNING;
                  rot_head_ff <= (rot_head_ff == LASTI) ? '0 : rot_head_ff + 1'b1;
                  rot_cnt_ff <= rot_cnt_ff - 1'b1;
               end else run_valid_ff <= 1'b0;
            end
            // present the result item
            tls_pkg::S_DONE: begin
               rsp_running_valid <= started_ff && !halted_ff && run_valid_ff;
               rsp_running_task <= (started_ff && !halted_ff && run_valid_ff)
                                   ? 4'(cur_ff) : 4'd0;
               rsp_created_task <= 4'(made_ff);
               rsp_status <= sts_ff;
               rsp_time_ms <= ms_ff;
               state_ff <= tls_pkg::S_IDLE;
            end
            default: state_ff <= tls_pkg::S_IDLE;
         endcase
      end
   end

   // checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      sys_cnt_ff <= MAXC && rot_cnt_ff <= MAXC) else $error("fifo count overflow");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt cleared");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the three-level task scheduler
// A directed table of events runs first, then bursts of random events under
// several quantum settings. Results are checked against an in-bench scheduler
// model that is updated as each item is accepted, or against the hand-written result of a directed row.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [2:0] OP_BAD_LO  = 3'd6;
   localparam logic [2:0] OP_BAD_HI  = 3'd7;
   localparam logic [1:0] CL_NONE    = 2'd3;
   localparam int         Q_SYS      = 0;
   localparam int         Q_RR       = 1;
   localparam int         SLOTS      = 16;
   localparam int         DRAIN_WAIT = 2 * SLOTS + 8;
   localparam int         CYCLE_CAP  = 600000;
   localparam int         PHASE_LEN  = 260;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [1:0]  req_task_class;
   logic [15:0] req_period;
   logic [15:0] req_offset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        rsp_valid;
   logic [3:0]  rsp_running_task;
   logic        rsp_running_valid;
   logic [3:0]  rsp_created_task;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_time_ms;

   typedef struct packed {
      logic [3:0]  running_task;
      logic        running_valid;
      logic [3:0]  created_task;
      logic [1:0]  status;
      logic [15:0] time_ms;
   } sched_res_type;

   typedef struct {
      logic [1:0]  slot_st[SLOTS];
      logic [1:0]  slot_cl[SLOTS];
      logic [15:0] slot_per[SLOTS];
      logic [15:0] slot_cd[SLOTS];
      logic [3:0]  q[2][SLOTS];
      logic [3:0]  qh[2];
      logic [3:0]  qt[2];
      logic [4:0]  qn[2];
      logic [3:0]  plist[SLOTS];
      logic [4:0]  pcount;
      logic        pr_valid;
      logic [3:0]  pr_id;
      logic [3:0]  cur;
      logic        run;
      logic [4:0]  live;
      logic        started;
      logic        halted;
      logic [15:0] ms;
      logic [7:0]  quantum;
   } sched_type;

   typedef struct packed {
      logic [2:0]    op;
      logic [1:0]    cls;
      logic [15:0]   per;
      logic [15:0]   off;
      logic          typed;
      sched_res_type res;
   } stim_row_type;

   sched_type     sched_shadow;
   sched_res_type pending_results[$];
   int            error_count;
   int            cycle_count;

   three_level_task_scheduler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_task_class   (req_task_class),
      .req_period       (req_period),
      .req_offset       (req_offset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_running_task (rsp_running_task),
      .rsp_running_valid(rsp_running_valid),
      .rsp_created_task (rsp_created_task),
      .rsp_status       (rsp_status),
      .rsp_time_ms      (rsp_time_ms)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic void queue_push(ref sched_type s, input int w, input logic [3:0] id);
      if (s.qn[w] >= SLOTS) return;
      s.q[w][s.qt[w]] = id;
      s.qt[w]++;
      s.qn[w]++;
   endfunction

   function automatic logic [3:0] queue_pop(ref sched_type s, input int w);
      logic [3:0] id;
      id = s.q[w][s.qh[w]];
      s.qh[w]++;
      s.qn[w]--;
      return id;
   endfunction

   function automatic logic [7:0] eff_quantum(ref sched_type s);
      return (s.quantum == 8'd0) ? 8'd1 : s.quantum;
   endfunction

   // pick the next task: system fifo, then ready periodic, then rotation
   function automatic void pick_next(ref sched_type s);
      logic [3:0] id;
      if (s.qn[Q_SYS] > 0) id = queue_pop(s, Q_SYS);
      else if (s.pr_valid) begin
         id = s.pr_id;
         s.pr_valid = 1'b0;
      end else if (s.qn[Q_RR] > 0) id = queue_pop(s, Q_RR);
      else begin
         s.run = 1'b0;
         return;
      end
      s.cur = id;
      s.run = 1'b1;
      s.slot_st[id] = tls_pkg::ST_RUNNING;
   endfunction

   // advance the scheduler model by one event
   function automatic void predict_event(ref sched_type s, input logic [2:0] op,
                                         input logic [1:0] cls, input logic [15:0] per,
                                         input logic [15:0] off, output sched_res_type r);
      logic [1:0]  sts;
      logic [3:0]  made;
      logic [3:0]  c;
      logic [1:0]  ccl;
      logic [15:0] cd;
      logic        pre;
      logic        found;
      logic        stop;
      int          slot;
      sts  = tls_pkg::STS_OK;
      made = 4'd0;
      if (s.halted) sts = tls_pkg::STS_IGNORED;
      else begin
         case (op)
            tls_pkg::OP_CREATE: begin
               found = 1'b0;
               slot  = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (!found && s.slot_st[i] == tls_pkg::ST_DEAD) begin
                     found = 1'b1;
                     slot  = i;
                  end
               if (cls > tls_pkg::CL_RR) sts = tls_pkg::STS_IGNORED;
               else if (s.live >= SLOTS || !found) sts = tls_pkg::STS_FULL;
               else begin
                  s.slot_cl[slot]  = cls;
                  s.slot_per[slot] = 16'd0;
                  s.slot_cd[slot]  = 16'd0;
                  if (cls == tls_pkg::CL_SYSTEM) begin
                     s.slot_st[slot] = tls_pkg::ST_READY;
                     queue_push(s, Q_SYS, slot[3:0]);
                  end else if (cls == tls_pkg::CL_PERIODIC) begin
                     s.slot_st[slot]  = tls_pkg::ST_WAITING;
                     s.slot_per[slot] = per;
                     s.slot_cd[slot]  = off;
                     if (s.pcount < SLOTS) begin
                        s.plist[s.pcount] = slot[3:0];
                        s.pcount++;
                     end
                  end else begin
                     s.slot_st[slot] = tls_pkg::ST_READY;
                     s.slot_cd[slot] = {8'd0, eff_quantum(s)};
                     queue_push(s, Q_RR, slot[3:0]);
                  end
                  s.live++;
                  made = slot[3:0];
               end
            end
            tls_pkg::OP_START: begin
               if (s.started || s.live == 0) sts = tls_pkg::STS_IGNORED;
               else begin
                  s.started = 1'b1;
                  pick_next(s);
               end
            end
            tls_pkg::OP_YIELD, tls_pkg::OP_TERMINATE: begin
               if (!s.started) sts = tls_pkg::STS_IGNORED;
               else begin
                  c = s.cur;
                  if (s.run && op == tls_pkg::OP_YIELD) begin
                     if (s.slot_cl[c] == tls_pkg::CL_PERIODIC)
                        s.slot_st[c] = tls_pkg::ST_WAITING;
                     else begin
                        s.slot_st[c] = tls_pkg::ST_READY;
                        queue_push(s, (s.slot_cl[c] == tls_pkg::CL_SYSTEM) ? Q_SYS : Q_RR,
                                   c);
                     end
                  end else if (s.run) begin
                     s.slot_st[c] = tls_pkg::ST_DEAD;
                     if (s.live > 0) s.live--;
                     if (s.slot_cl[c] == tls_pkg::CL_PERIODIC) begin
                        found = 1'b0;
                        for (int i = 0; i < SLOTS; i++)
                           if (i < s.pcount) begin
                              if (found) s.plist[i-1] = s.plist[i];
                              else if (s.plist[i] == c) found = 1'b1;
                           end
                        if (found) s.pcount--;
                        if (s.pr_valid && s.pr_id == c) s.pr_valid = 1'b0;
                     end
                  end
                  s.run = 1'b0;
                  pick_next(s);
               end
            end
            tls_pkg::OP_MS_TICK: begin
               s.ms++;
               if (s.started && !s.run) pick_next(s);
               else if (s.started) begin
                  c   = s.cur;
                  ccl = s.slot_cl[c];
                  pre = (ccl == tls_pkg::CL_RR && (s.qn[Q_SYS] > 0 || s.pr_valid)) ||
                        (ccl == tls_pkg::CL_PERIODIC && s.qn[Q_SYS] > 0);
                  if (ccl == tls_pkg::CL_RR) begin
                     cd = s.slot_cd[c] - 16'd1;
                     if (cd == 16'd0) begin
                        cd  = {8'd0, eff_quantum(s)};
                        pre = 1'b1;
                     end
                     s.slot_cd[c] = cd;
                  end
                  if (pre) begin
                     s.slot_st[c] = tls_pkg::ST_READY;
                     if (ccl == tls_pkg::CL_PERIODIC && s.pr_valid) begin
                        s.halted = 1'b1;
                        sts      = tls_pkg::STS_HALTED;
                     end else begin
                        if (ccl == tls_pkg::CL_SYSTEM) queue_push(s, Q_SYS, c);
                        else if (ccl == tls_pkg::CL_PERIODIC) begin
                           s.pr_valid = 1'b1;
                           s.pr_id    = c;
                        end else queue_push(s, Q_RR, c);
                        s.run = 1'b0;
                        pick_next(s);
                     end
                  end
               end
            end
            tls_pkg::OP_PER_TICK: begin
               stop = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (!stop && i < s.pcount) begin
                     c  = s.plist[i];
                     cd = s.slot_cd[c] - 16'd1;
                     if (cd == 16'd0) begin
                        s.slot_cd[c] = s.slot_per[c];
                        if (s.slot_st[c] != tls_pkg::ST_RUNNING)
                           s.slot_st[c] = tls_pkg::ST_READY;
                        if (s.pr_valid) begin
                           s.halted = 1'b1;
                           sts      = tls_pkg::STS_HALTED;
                           stop     = 1'b1;
                        end else begin
                           s.pr_valid = 1'b1;
                           s.pr_id    = c;
                        end
                     end else s.slot_cd[c] = cd;
                  end
            end
            default: sts = tls_pkg::STS_IGNORED;
         endcase
      end
      r.running_valid = s.started && !s.halted && s.run;
      r.running_task  = r.running_valid ? s.cur : 4'd0;
      r.created_task  = made;
      r.status        = sts;
      r.time_ms       = s.ms;
   endfunction

   // ---------------------------------------------------------------- driving
   // busy is looked at on the falling edge, so the next rising edge takes the item
   task automatic send_event(input logic [2:0] op, input logic [1:0] cls,
                             input logic [15:0] per, input logic [15:0] off,
                             input logic typed, input sched_res_type typed_res);
      sched_res_type r;
      @(negedge clock);
      while (busy) @(negedge clock);
      req_op         = op;
      req_task_class = cls;
      req_period     = per;
      req_offset     = off;
      start          = 1'b1;
      @(posedge clock);
      predict_event(sched_shadow, op, cls, per, off, r);
      pending_results.push_back(typed ? typed_res : r);
      @(negedge clock);
      start = 1'b0;
   endtask

   // quantum written only once the block has drained
   task automatic write_quantum(input logic [7:0] value);
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sched_shadow.quantum = value;
   endtask

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 16'hFFFF;
         1:       return 16'd0;
         2, 3, 4: return 16'($urandom);
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic pick_event(output logic [2:0] op, output logic [1:0] cls,
                             output logic [15:0] per, output logic [15:0] off);
      int w;
      w   = $urandom_range(0, 99);
      cls = 2'($urandom);
      per = pick_count();
      off = pick_count();
      if (w < 26) begin
         op = tls_pkg::OP_CREATE;
         w  = $urandom_range(0, 99);
         cls = (w < 30) ? tls_pkg::CL_SYSTEM : (w < 50) ? tls_pkg::CL_PERIODIC :
               (w < 95) ? tls_pkg::CL_RR : CL_NONE;
      end else if (w < 29) op = tls_pkg::OP_START;
      else if (w < 44) op = tls_pkg::OP_YIELD;
      else if (w < 56) op = tls_pkg::OP_TERMINATE;
      else if (w < 82) op = tls_pkg::OP_MS_TICK;
      else if (w < 97) op = tls_pkg::OP_PER_TICK;
      else op = $urandom_range(0, 1) ? OP_BAD_LO : OP_BAD_HI;
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report(input string field, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got,
               want);
      error_count++;
   endtask

   always @(posedge clock) begin
      sched_res_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) report("unexpected item", 1, 0);
         else begin
            want = pending_results.pop_front();
            if (rsp_running_task !== want.running_task)
               report("running_task", rsp_running_task, want.running_task);
            if (rsp_running_valid !== want.running_valid)
               report("running_valid", rsp_running_valid, want.running_valid);
            if (rsp_created_task !== want.created_task)
               report("created_task", rsp_created_task, want.created_task);
            if (rsp_status !== want.status)
               report("status", rsp_status, want.status);
            if (rsp_time_ms !== want.time_ms)
               report("time_ms", rsp_time_ms, want.time_ms);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      stim_row_type  stim[24];
      sched_type     trial;
      sched_res_type tr;
      sched_res_type none;
      logic [2:0]  op;
      logic [1:0]  cls;
      logic [15:0] per;
      logic [15:0] off;
      logic        ok;
      int          burst;
      logic [7:0]  quanta[5];

      reset          = 1'b1;
      start          = 1'b0;
      req_op         = tls_pkg::OP_CREATE;
      req_task_class = tls_pkg::CL_SYSTEM;
      req_period     = 16'd0;
      req_offset     = 16'd0;
      csr_we         = 1'b0;
      csr_wdata      = 8'd0;
      error_count    = 0;
      cycle_count    = 0;
      none           = '0;

      for (int i = 0; i < SLOTS; i++) begin
         sched_shadow.slot_st[i]  = tls_pkg::ST_DEAD;
         sched_shadow.slot_cl[i]  = tls_pkg::CL_SYSTEM;
         sched_shadow.slot_per[i] = 16'd0;
         sched_shadow.slot_cd[i]  = 16'd0;
         sched_shadow.q[0][i]     = 4'd0;
         sched_shadow.q[1][i]     = 4'd0;
         sched_shadow.plist[i]    = 4'd0;
      end
      sched_shadow.qh       = '{4'd0, 4'd0};
      sched_shadow.qt       = '{4'd0, 4'd0};
      sched_shadow.qn       = '{5'd0, 5'd0};
      sched_shadow.pcount   = 5'd0;
      sched_shadow.pr_valid = 1'b0;
      sched_shadow.pr_id    = 4'd0;
      sched_shadow.cur      = 4'd0;
      sched_shadow.run      = 1'b0;
      sched_shadow.live     = 5'd0;
      sched_shadow.started  = 1'b0;
      sched_shadow.halted   = 1'b0;
      sched_shadow.ms       = 16'd0;
      sched_shadow.quantum  = 8'd10;

      // directed events; the first rows carry their result by hand
      stim[0]  = '{tls_pkg::OP_MS_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_OK, 16'd1}};
      stim[1]  = '{tls_pkg::OP_START, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_IGNORED, 16'd1}};
      stim[2]  = '{tls_pkg::OP_YIELD, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_IGNORED, 16'd1}};
      stim[3]  = '{OP_BAD_LO, tls_pkg::CL_SYSTEM, 16'hFFFF, 16'hFFFF, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_IGNORED, 16'd1}};
      stim[4]  = '{OP_BAD_HI, CL_NONE, 16'd0, 16'd0, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_IGNORED, 16'd1}};
      stim[5]  = '{tls_pkg::OP_CREATE, CL_NONE, 16'd5, 16'd5, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_IGNORED, 16'd1}};
      stim[6]  = '{tls_pkg::OP_CREATE, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b1,
                   '{4'd0, 1'b0, 4'd0, tls_pkg::STS_OK, 16'd1}};
      stim[7]  = '{tls_pkg::OP_CREATE, tls_pkg::CL_PERIODIC, 16'd2, 16'd0, 1'b0, none};
      stim[8]  = '{tls_pkg::OP_CREATE, tls_pkg::CL_RR, 16'd0, 16'd0, 1'b0, none};
      stim[9]  = '{tls_pkg::OP_CREATE, tls_pkg::CL_PERIODIC, 16'd0, 16'd1, 1'b0, none};
      stim[10] = '{tls_pkg::OP_START, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[11] = '{tls_pkg::OP_PER_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[12] = '{tls_pkg::OP_MS_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[13] = '{tls_pkg::OP_YIELD, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[14] = '{tls_pkg::OP_TERMINATE, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[15] = '{tls_pkg::OP_PER_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[16] = '{tls_pkg::OP_MS_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[17] = '{tls_pkg::OP_YIELD, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[18] = '{tls_pkg::OP_MS_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[19] = '{tls_pkg::OP_CREATE, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[20] = '{tls_pkg::OP_MS_TICK, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[21] = '{tls_pkg::OP_TERMINATE, tls_pkg::CL_SYSTEM, 16'd0, 16'd0, 1'b0, none};
      stim[22] = '{tls_pkg::OP_CREATE, tls_pkg::CL_PERIODIC, 16'hFFFF, 16'hFFFF, 1'b0,
                   none};
      stim[23] = '{OP_BAD_HI, tls_pkg::CL_RR, 16'hAAAA, 16'h5555, 1'b0, none};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim[i])
         send_event(stim[i].op, stim[i].cls, stim[i].per, stim[i].off, stim[i].typed,
                    stim[i].res);

      // random phases, one quantum per phase; halts only in the last one
      quanta = '{8'd10, 8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd1};
      foreach (quanta[p]) begin
         if (p > 0) write_quantum(quanta[p]);
         burst = 0;
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 9)) @(negedge clock);
            end
            burst--;
            ok = 1'b0;
            for (int t = 0; t < 8 && !ok; t++) begin
               pick_event(op, cls, per, off);
               trial = sched_shadow;
               predict_event(trial, op, cls, per, off, tr);
               ok = (p == 4) || (tr.status != tls_pkg::STS_HALTED);
            end
            if (!ok) op = OP_BAD_LO;
            send_event(op, cls, per, off, 1'b0, none);
         end
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
